// ----- hdl/per_symbol_vwap_aggregator_top_assert.svh -----
// Assertion macros shared by the aggregator RTL.
`ifndef PER_SYMBOL_VWAP_AGGREGATOR_TOP_ASSERT_SVH
`define PER_SYMBOL_VWAP_AGGREGATOR_TOP_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define PSVA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define PSVA_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/psva_pkg.sv -----
// ----------------------------------------------------------------------------
// Per-symbol VWAP aggregator package
// Shared types and constants of the aggregator.
// ----------------------------------------------------------------------------
`default_nettype none
package psva_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int KEY_W = 64;
    localparam int PRICE_W = 32;
    localparam int VOL_W = 48;
    localparam int SUM_W = 64;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [VOL_W-1:0]   volume;
        logic [SUM_W-1:0]   wsum;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] high;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KRD,
        S_KCMP,
        S_MISS,
        S_MUL,
        S_ACC,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/psva_if.sv -----
// ----------------------------------------------------------------------------
// Aggregator channel interfaces
// Valid/ready channels for the request and the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none
interface psva_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [psva_pkg::KEY_W-1:0]     symbol_key;
    logic [psva_pkg::PRICE_W-1:0]   trade_price;
    logic [psva_pkg::PRICE_W-1:0]   trade_volume;

    modport source(output valid, mode, symbol_key, trade_price, trade_volume, input ready);
    modport sink(input valid, mode, symbol_key, trade_price, trade_volume, output ready);
endinterface

interface psva_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [psva_pkg::STAT_W-1:0]    status;
    logic [psva_pkg::PRICE_W-1:0]   vwap;
    logic [psva_pkg::PRICE_W-1:0]   low_price;
    logic [psva_pkg::PRICE_W-1:0]   high_price;
    logic [psva_pkg::VOL_W-1:0]     volume_total;

    modport source(output valid, status, vwap, low_price, high_price, volume_total,
                   input ready);
    modport sink(input valid, status, vwap, low_price, high_price, volume_total,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/per_symbol_vwap_aggregator_top.sv -----
// ----------------------------------------------------------------------------
// Per-symbol VWAP aggregator
// Keeps volume, weighted price sum and price range per trading symbol.
// ----------------------------------------------------------------------------
// Requests arrive on i_req: mode 0 adds a trade to a symbol, mode 1 queries
// it. Every request gives exactly one result transfer on o_rsp.
// One request is handled at a time. The lookup reads the key memory one
// entry at a time, a read state S_KRD and a compare state S_KCMP per
// entry, up to the match or the fill count. A found or allocated entry
// then passes the update states S_MUL and S_ACC and waits in S_DIV for the
// bit-serial divider that forms the VWAP. Misses on a query or on a full
// table go from S_MISS straight to S_DONE. Entries are allocated in order
// and never freed, so a fill count marks the valid entries and reset needs
// no clearing pass; the table is empty after reset. The result waits in an
// output register; a stalled receiver holds back only the next result, and
// a new request is taken in the meantime.
// ----------------------------------------------------------------------------
`default_nettype none
module per_symbol_vwap_aggregator_top #(
    parameter int TABLE_DEPTH = psva_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    psva_req_if.sink    i_req,
    psva_rsp_if.source  o_rsp
);
    import psva_pkg::*;
    `include "per_symbol_vwap_aggregator_top_assert.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic               r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [PRICE_W-1:0] r_price;
    logic [PRICE_W-1:0] r_vol;
    t_entry             r_ent;
    logic [SUM_W-1:0]   r_prod;
    logic [PRICE_W-1:0] r_vadd;
    logic [STAT_W-1:0]  r_stat;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_stat;
    logic [PRICE_W-1:0] r_out_vwap;
    logic [PRICE_W-1:0] r_out_low;
    logic [PRICE_W-1:0] r_out_high;
    logic [VOL_W-1:0]   r_out_vol;

    logic               w_accept;
    logic               w_match;
    logic               w_last;
    logic [CW-1:0]      w_idx_inc;
    logic               w_full;
    logic               w_load_out;
    logic [KEY_W-1:0]   w_rd_key;
    t_entry             w_rd_ent;
    t_entry             w_new_ent;
    logic [VOL_W:0]     w_vol_sum;
    logic [SUM_W:0]     w_wsum_sum;
    logic               w_div_start;
    logic               w_div_busy;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_quo;
    logic               w_key_we;
    logic               w_ent_we;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_match = (w_rd_key == r_key);
    assign w_idx_inc = CW'(r_idx) + CW'(1);
    assign w_last = (w_idx_inc == r_count);
    assign w_full = (r_count == CW'(TABLE_DEPTH));
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign w_vol_sum = {1'b0, r_ent.volume} + (VOL_W + 1)'(r_vadd);
    assign w_wsum_sum = {1'b0, r_ent.wsum} + {1'b0, r_prod};

    always_comb begin
        w_new_ent = r_ent;
        w_new_ent.volume = w_vol_sum[VOL_W] ? '1 : w_vol_sum[VOL_W-1:0];
        w_new_ent.wsum = w_wsum_sum[SUM_W] ? '1 : w_wsum_sum[SUM_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (r_count == '0) ? S_MISS : S_KRD;
                end
            end
            S_KRD: n_state = S_KCMP;
            S_KCMP: begin
                if (w_match) begin
                    n_state = S_MUL;
                end else if (w_last) begin
                    n_state = S_MISS;
                end else begin
                    n_state = S_KRD;
                end
            end
            S_MISS: begin
                if (r_mode == MODE_QUERY || w_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_key_we = (r_state == S_MISS) && (r_mode == MODE_UPDATE) && !w_full;
        w_ent_we = (r_state == S_ACC) && (r_mode == MODE_UPDATE);
        w_div_start = (r_state == S_ACC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_key_we) begin
                r_count <= r_count + CW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_req.mode;
            r_key <= i_req.symbol_key;
            r_price <= i_req.trade_price;
            r_vol <= i_req.trade_volume;
            r_idx <= '0;
        end
        if (r_state == S_KCMP) begin
            if (w_match) begin
                r_ent <= w_rd_ent;
                r_stat <= ST_OK;
            end else if (!w_last) begin
                r_idx <= w_idx_inc[AW-1:0];
            end
        end
        if (r_state == S_MISS) begin
            r_idx <= r_count[AW-1:0];
            r_ent.volume <= '0;
            r_ent.wsum <= '0;
            r_ent.low <= r_price;
            r_ent.high <= r_price;
            if (r_mode == MODE_QUERY) begin
                r_stat <= ST_MISS;
            end else if (w_full) begin
                r_stat <= ST_FULL;
            end else begin
                r_stat <= ST_OK;
            end
        end
        if (r_state == S_MUL) begin
            if (r_mode == MODE_UPDATE) begin
                r_prod <= SUM_W'(r_vol) * SUM_W'(r_price);
                r_vadd <= r_vol;
                if (r_price < r_ent.low) begin
                    r_ent.low <= r_price;
                end
                if (r_price > r_ent.high) begin
                    r_ent.high <= r_price;
                end
            end else begin
                r_prod <= '0;
                r_vadd <= '0;
            end
        end
        if (r_state == S_ACC) begin
            r_ent <= w_new_ent;
        end
        if (w_load_out) begin
            r_out_stat <= r_stat;
            if (r_stat == ST_OK) begin
                if (r_ent.volume == '0) begin
                    r_out_vwap <= '0;
                end else if (w_quo[SUM_W-1:PRICE_W] != '0) begin
                    r_out_vwap <= '1;
                end else begin
                    r_out_vwap <= w_quo[PRICE_W-1:0];
                end
                r_out_low <= r_ent.low;
                r_out_high <= r_ent.high;
                r_out_vol <= r_ent.volume;
            end else begin
                r_out_vwap <= '0;
                r_out_low <= '0;
                r_out_high <= '0;
                r_out_vol <= '0;
            end
        end
    end

    psva_mem #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .AW(AW)
    ) u_mem (
        .i_clk(i_clk),
        .i_rd_addr(r_idx),
        .i_key_we(w_key_we),
        .i_key_waddr(r_count[AW-1:0]),
        .i_key_wdata(r_key),
        .i_ent_we(w_ent_we),
        .i_ent_waddr(r_idx),
        .i_ent_wdata(w_new_ent),
        .o_key_rdata(w_rd_key),
        .o_ent_rdata(w_rd_ent)
    );

    psva_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_dividend(w_new_ent.wsum),
        .i_divisor(w_new_ent.volume),
        .o_busy(w_div_busy),
        .o_done(w_div_done),
        .o_quotient(w_quo)
    );

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.status = r_out_stat;
    assign o_rsp.vwap = r_out_vwap;
    assign o_rsp.low_price = r_out_low;
    assign o_rsp.high_price = r_out_high;
    assign o_rsp.volume_total = r_out_vol;

    `PSVA_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(TABLE_DEPTH), "fill count past depth")
    `PSVA_ASSERT_ALWAYS(a_scan_in_fill, (r_state != S_KCMP) || (CW'(r_idx) < r_count), "scan past fill count")
    `PSVA_ASSERT_ALWAYS(a_div_in_state, !w_div_busy || (r_state == S_DIV), "divider busy outside wait")
    `PSVA_ASSERT_NEXT(a_alloc_grows, w_key_we, r_count == $past(r_count) + CW'(1), "allocation lost")
endmodule
`default_nettype wire

// ----- hdl/psva_div.sv -----
// ----------------------------------------------------------------------------
// VWAP divider
// Restoring divider, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
`default_nettype none
module psva_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [psva_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [psva_pkg::VOL_W-1:0]   i_divisor,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [psva_pkg::SUM_W-1:0]        o_quotient
);
    import psva_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [SUM_W-1:0] r_quo;
    logic [SUM_W-1:0] n_quo;
    logic [VOL_W-1:0] r_rem;
    logic [VOL_W-1:0] n_rem;
    logic [VOL_W-1:0] r_den;
    logic [VOL_W:0]   w_sh;
    logic [VOL_W:0]   w_diff;

    assign w_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = CNT_W'(SUM_W);
            n_busy = 1'b1;
            n_quo = i_dividend;
            n_rem = '0;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_diff[VOL_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[VOL_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- hdl/psva_mem.sv -----
// ----------------------------------------------------------------------------
// Symbol table memories
// Key memory and metrics memory, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none
module psva_mem #(
    parameter int TABLE_DEPTH = psva_pkg::DEF_TABLE_DEPTH,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic [AW-1:0]              i_rd_addr,
    input  wire logic                       i_key_we,
    input  wire logic [AW-1:0]              i_key_waddr,
    input  wire logic [psva_pkg::KEY_W-1:0] i_key_wdata,
    input  wire logic                       i_ent_we,
    input  wire logic [AW-1:0]              i_ent_waddr,
    input  wire psva_pkg::t_entry           i_ent_wdata,
    output logic [psva_pkg::KEY_W-1:0]      o_key_rdata,
    output psva_pkg::t_entry                o_ent_rdata
);
    import psva_pkg::*;

    logic [KEY_W-1:0] m_key [TABLE_DEPTH];
    t_entry           m_ent [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            m_key[i_key_waddr] <= i_key_wdata;
        end
        o_key_rdata <= m_key[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            m_ent[i_ent_waddr] <= i_ent_wdata;
        end
        o_ent_rdata <= m_ent[i_rd_addr];
    end
endmodule
`default_nettype wire

// ----- tb/sv/tb_psva_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aggregator scoreboard
// Tracks the symbol table and checks each result transfer against it.
// ----------------------------------------------------------------------------
`default_nettype none
class psva_scoreboard;
    typedef struct packed {
        logic [psva_pkg::STAT_W-1:0]  status;
        logic [psva_pkg::PRICE_W-1:0] vwap;
        logic [psva_pkg::PRICE_W-1:0] low_price;
        logic [psva_pkg::PRICE_W-1:0] high_price;
        logic [psva_pkg::VOL_W-1:0]   volume_total;
    } t_metrics;

    int depth;
    bit                            sym_used[];
    logic [psva_pkg::KEY_W-1:0]    sym_key[];
    logic [psva_pkg::VOL_W-1:0]    sym_volume[];
    logic [psva_pkg::SUM_W-1:0]    sym_wsum[];
    logic [psva_pkg::PRICE_W-1:0]  sym_low[];
    logic [psva_pkg::PRICE_W-1:0]  sym_high[];
    t_metrics pending_metrics[$];
    int errors;
    int n_checked;
    int n_full;
    int n_miss;

    function new(int table_depth);
        depth = table_depth;
        sym_used = new[depth];
        sym_key = new[depth];
        sym_volume = new[depth];
        sym_wsum = new[depth];
        sym_low = new[depth];
        sym_high = new[depth];
        foreach (sym_used[i]) sym_used[i] = 0;
        errors = 0;
        n_checked = 0;
        n_full = 0;
        n_miss = 0;
    endfunction

    function t_metrics metrics_of(int idx);
        t_metrics m;
        logic [63:0] q;
        m = '0;
        m.status = psva_pkg::ST_OK;
        if (sym_volume[idx] != 0) begin
            q = sym_wsum[idx] / {16'd0, sym_volume[idx]};
            m.vwap = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        end
        m.low_price = sym_low[idx];
        m.high_price = sym_high[idx];
        m.volume_total = sym_volume[idx];
        return m;
    endfunction

    function void note_request(logic mode, logic [63:0] key, logic [31:0] price,
                               logic [31:0] vol);
        int idx;
        t_metrics m;
        logic [48:0] nv;
        logic [63:0] prod;
        logic [64:0] ns;
        idx = -1;
        m = '0;
        for (int i = 0; i < depth; i++) begin
            if (idx < 0 && sym_used[i] && sym_key[i] == key) idx = i;
        end
        if (mode == psva_pkg::MODE_QUERY) begin
            if (idx < 0) m.status = psva_pkg::ST_MISS;
            else m = metrics_of(idx);
            pending_metrics.push_back(m);
            return;
        end
        if (idx < 0) begin
            for (int i = 0; i < depth; i++) begin
                if (idx < 0 && !sym_used[i]) idx = i;
            end
            if (idx < 0) begin
                m.status = psva_pkg::ST_FULL;
                pending_metrics.push_back(m);
                return;
            end
            sym_used[idx] = 1;
            sym_key[idx] = key;
            sym_volume[idx] = '0;
            sym_wsum[idx] = '0;
            sym_low[idx] = price;
            sym_high[idx] = price;
        end else begin
            if (price < sym_low[idx]) sym_low[idx] = price;
            if (price > sym_high[idx]) sym_high[idx] = price;
        end
        nv = {1'b0, sym_volume[idx]} + {17'd0, vol};
        prod = {32'd0, vol} * {32'd0, price};
        ns = {1'b0, sym_wsum[idx]} + {1'b0, prod};
        sym_volume[idx] = nv[48] ? {48{1'b1}} : nv[47:0];
        sym_wsum[idx] = ns[64] ? {64{1'b1}} : ns[63:0];
        pending_metrics.push_back(metrics_of(idx));
    endfunction

    function void check_result(t_metrics got);
        t_metrics exp_m;
        if (pending_metrics.size() == 0) begin
            $display("%0t: result with none expected: %h", $realtime, got);
            errors++;
            return;
        end
        exp_m = pending_metrics.pop_front();
        n_checked++;
        if (got.status == psva_pkg::ST_FULL) n_full++;
        if (got.status == psva_pkg::ST_MISS) n_miss++;
        if (got.status !== exp_m.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_m.status, got.status);
            errors++;
        end
        if (got.vwap !== exp_m.vwap) begin
            $display("%0t: vwap expected %0d actual %0d", $realtime, exp_m.vwap, got.vwap);
            errors++;
        end
        if (got.low_price !== exp_m.low_price) begin
            $display("%0t: low_price expected %0d actual %0d", $realtime, exp_m.low_price,
                     got.low_price);
            errors++;
        end
        if (got.high_price !== exp_m.high_price) begin
            $display("%0t: high_price expected %0d actual %0d", $realtime, exp_m.high_price,
                     got.high_price);
            errors++;
        end
        if (got.volume_total !== exp_m.volume_total) begin
            $display("%0t: volume_total expected %0d actual %0d", $realtime,
                     exp_m.volume_total, got.volume_total);
            errors++;
        end
    endfunction
endclass
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aggregator testbench
// Sends trades and queries with random gaps and receiver stalls, predicts
// every result from a software symbol table and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import psva_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    logic i_clk;
    logic i_rst_n;
    psva_req_if req_ch();
    psva_rsp_if rsp_ch();

    per_symbol_vwap_aggregator_top #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    psva_scoreboard symbol_book;
    logic [63:0] ticker_pool[16];
    bit no_idle;
    bit hold_rsp;
    bit stim_done;
    int n_sent;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(logic mode, logic [63:0] key, logic [31:0] price,
                                logic [31:0] vol);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.symbol_key <= key;
        req_ch.trade_price <= price;
        req_ch.trade_volume <= vol;
        do @(posedge i_clk); while (!req_ch.ready);
        symbol_book.note_request(mode, key, price, vol);
        n_sent++;
    endtask

    task automatic drop_request();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_request();
        while (symbol_book.pending_metrics.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_price();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom_range(2000000, 1000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_volume();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom_range(5000);
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (hold_rsp) rsp_ch.ready <= 1'b0;
        else if (!no_idle) rsp_ch.ready <= ($urandom_range(99) >= 7);
        else rsp_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            symbol_book.check_result({rsp_ch.status, rsp_ch.vwap, rsp_ch.low_price,
                                      rsp_ch.high_price, rsp_ch.volume_total});
        end
    end

    initial begin
        int tail;
        logic [63:0] key;
        symbol_book = new(DEPTH);
        no_idle = 1'b0;
        hold_rsp = 1'b0;
        n_sent = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_UPDATE;
        req_ch.symbol_key = '0;
        req_ch.trade_price = '0;
        req_ch.trade_volume = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < 16; i++) ticker_pool[i] = {$urandom, $urandom};
        ticker_pool[0] = 64'h0;
        ticker_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        ticker_pool[2] = 64'h4141_504C_0000_0000;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: misses, key extremes, zero volume, saturation of the weighted price sum.
        send_request(MODE_QUERY, ticker_pool[0], 32'd5, 32'd5);
        send_request(MODE_UPDATE, ticker_pool[0], 32'd1000, 32'd0);
        send_request(MODE_QUERY, ticker_pool[0], 32'd0, 32'd0);
        send_request(MODE_UPDATE, ticker_pool[0], 32'd500, 32'd10);
        send_request(MODE_UPDATE, ticker_pool[0], 32'd2000, 32'd30);
        send_request(MODE_UPDATE, ticker_pool[1], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_request(MODE_UPDATE, ticker_pool[1], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_UPDATE, ticker_pool[1], 32'd0, 32'd1);
        send_request(MODE_QUERY, ticker_pool[1], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_UPDATE, ticker_pool[2], 32'd0, 32'hFFFF_FFFF);
        send_request(MODE_QUERY, ticker_pool[2], 32'd0, 32'd0);
        send_request(MODE_QUERY, 64'h5A5A_5A5A_5A5A_5A5A, 32'd0, 32'd0);
        wait_drained();

        // Receiver holds off while requests keep coming.
        fork
            begin
                hold_rsp = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_rsp = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_request($urandom_range(1), ticker_pool[$urandom_range(15)],
                                 rand_price(), rand_volume());
                drop_request();
            end
        join

        for (int n = 0; n < 540; n++) begin
            no_idle = (n >= 150 && n < 230);
            if (n == 300) wait_drained();
            if (n < 260) key = ticker_pool[$urandom_range(15)];
            else if ($urandom_range(9) < 7) key = {32'h5359_4D00, 32'(n % 80)};
            else key = {$urandom, $urandom};
            send_request(($urandom_range(3) == 0) ? MODE_QUERY : MODE_UPDATE, key,
                         rand_price(), rand_volume());
        end
        drop_request();
        no_idle = 1'b0;

        tail = 0;
        while (symbol_book.pending_metrics.size() != 0 && tail < 200000) begin
            @(negedge i_clk);
            tail++;
        end
        repeat (300) @(negedge i_clk);
        $display("Sent %0d requests, checked %0d results (%0d table full, %0d not found).",
                 n_sent, symbol_book.n_checked, symbol_book.n_full, symbol_book.n_miss);
        if (symbol_book.errors == 0 && symbol_book.pending_metrics.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
